>>> design/gszre_pkg.sv
// ---------------------------------------------------------------------------
// gszre_pkg
// Types, codes and widths shared by the gated sample zero-run encoder.
// ---------------------------------------------------------------------------
package gszre_pkg;

  localparam int InDataW  = 160;
  localparam int OutDataW = 272;
  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 32;

  typedef enum logic [1:0] {
    CMD_GATE   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_END    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ZERO_RUN = 2'd0,
    KIND_SAMPLE   = 2'd1,
    KIND_SUMMARY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_SCAN_START = 2'd0,
    REG_POST_TRIG  = 2'd1,
    REG_RANGE_SHFT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] scan_start;
    logic [31:0] post_trigger_offset;
    logic [16:0] range_shift;
  } cfg_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        upper_half;
    logic [31:0] gate_start;
    logic [31:0] gate_stop;
    logic [31:0] raw_word;
    logic [63:0] trigger_time;
  } item_t;

  typedef struct packed {
    logic        has_result;
    kind_t       kind;
    logic [31:0] value;
    logic [31:0] scan_number;
    logic [30:0] sample_total;
    logic [63:0] intensity_sum;
    logic [16:0] peak_value;
    logic [31:0] peak_position;
    logic [63:0] time_out;
  } result_t;

endpackage

>>> design/gszre_cfg_regs.sv
// ---------------------------------------------------------------------------
// gszre_cfg_regs
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
module gszre_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gszre_pkg::CfgAddrW-1:0]      paddr,
  input  logic [gszre_pkg::CfgDataW-1:0]      pwdata,
  output logic [gszre_pkg::CfgDataW-1:0]      prdata,
  output gszre_pkg::cfg_t                     cfg
);

  gszre_pkg::cfg_t     cfg_r;
  gszre_pkg::cfg_t     cfg_nxt;
  gszre_pkg::reg_idx_t idx;
  logic                wr_en;

  assign idx   = gszre_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        gszre_pkg::REG_SCAN_START: cfg_nxt.scan_start          = pwdata[30:0];
        gszre_pkg::REG_POST_TRIG:  cfg_nxt.post_trigger_offset = pwdata[31:0];
        gszre_pkg::REG_RANGE_SHFT: cfg_nxt.range_shift         = pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      gszre_pkg::REG_SCAN_START: prdata = {1'b0, cfg_r.scan_start};
      gszre_pkg::REG_POST_TRIG:  prdata = cfg_r.post_trigger_offset;
      gszre_pkg::REG_RANGE_SHFT: prdata = {15'd0, cfg_r.range_shift};
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> design/gszre_core.sv
// ---------------------------------------------------------------------------
// gszre_core
// Per-trigger state and the combinational encode of one registered request.
// ---------------------------------------------------------------------------
module gszre_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  gszre_pkg::item_t  item,
  input  gszre_pkg::cfg_t   cfg,
  output gszre_pkg::result_t res
);

  logic        first_gate_r,      first_gate_nxt;
  logic [31:0] previous_stop_r,   previous_stop_nxt;
  logic [31:0] zero_total_r,      zero_total_nxt;
  logic [31:0] emitted_samples_r, emitted_samples_nxt;
  logic [63:0] running_sum_r,     running_sum_nxt;
  logic [16:0] peak_so_far_r,     peak_so_far_nxt;
  logic [31:0] peak_index_r,      peak_index_nxt;
  logic [31:0] trigger_count_r,   trigger_count_nxt;

  logic [31:0] gap;
  logic        skip;
  logic        gap_pos;
  logic [15:0] half;
  logic [17:0] val;
  logic        new_peak;

  assign gap  = first_gate_r ? (item.gate_start + cfg.post_trigger_offset)
                             : (item.gate_start - previous_stop_r);
  assign skip    = (item.gate_stop <= item.gate_start);
  assign gap_pos = !gap[31] && (gap != 32'd0);

  assign half = item.upper_half ? item.raw_word[31:16] : item.raw_word[15:0];
  assign val  = {{2{half[15]}}, half} + {cfg.range_shift[16], cfg.range_shift};
  assign new_peak = !val[17] && (val[16:0] > peak_so_far_r);

  always_comb begin
    first_gate_nxt      = first_gate_r;
    previous_stop_nxt   = previous_stop_r;
    zero_total_nxt      = zero_total_r;
    emitted_samples_nxt = emitted_samples_r;
    running_sum_nxt     = running_sum_r;
    peak_so_far_nxt     = peak_so_far_r;
    peak_index_nxt      = peak_index_r;
    trigger_count_nxt   = trigger_count_r;
    res                 = '0;
    res.kind            = gszre_pkg::KIND_ZERO_RUN;
    if (fire) begin
      case (item.cmd)
        gszre_pkg::CMD_GATE: begin
          first_gate_nxt    = 1'b0;
          previous_stop_nxt = item.gate_stop;
          if (!skip) begin
            zero_total_nxt = zero_total_r + gap;
            if (gap_pos) begin
              res.has_result = 1'b1;
              res.kind       = gszre_pkg::KIND_ZERO_RUN;
              res.value      = 32'd0 - gap;
            end
          end
        end
        gszre_pkg::CMD_SAMPLE: begin
          if (new_peak) begin
            peak_so_far_nxt = val[16:0];
            peak_index_nxt  = emitted_samples_r + zero_total_r;
          end
          emitted_samples_nxt = emitted_samples_r + 32'd1;
          running_sum_nxt     = running_sum_r + {{46{val[17]}}, val};
          res.has_result      = 1'b1;
          res.kind            = gszre_pkg::KIND_SAMPLE;
          res.value           = {{14{val[17]}}, val};
        end
        gszre_pkg::CMD_END: begin
          res.has_result      = 1'b1;
          res.kind            = gszre_pkg::KIND_SUMMARY;
          res.scan_number     = {1'b0, cfg.scan_start} + trigger_count_r;
          res.sample_total    = emitted_samples_r[30:0];
          res.intensity_sum   = running_sum_r;
          res.peak_value      = peak_so_far_r;
          res.peak_position   = peak_index_r;
          res.time_out        = item.trigger_time;
          trigger_count_nxt   = trigger_count_r + 32'd1;
          first_gate_nxt      = 1'b1;
          previous_stop_nxt   = '0;
          zero_total_nxt      = '0;
          emitted_samples_nxt = '0;
          running_sum_nxt     = '0;
          peak_so_far_nxt     = '0;
          peak_index_nxt      = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_gate_r      <= 1'b1;
      previous_stop_r   <= '0;
      zero_total_r      <= '0;
      emitted_samples_r <= '0;
      running_sum_r     <= '0;
      peak_so_far_r     <= '0;
      peak_index_r      <= '0;
      trigger_count_r   <= '0;
    end else begin
      first_gate_r      <= first_gate_nxt;
      previous_stop_r   <= previous_stop_nxt;
      zero_total_r      <= zero_total_nxt;
      emitted_samples_r <= emitted_samples_nxt;
      running_sum_r     <= running_sum_nxt;
      peak_so_far_r     <= peak_so_far_nxt;
      peak_index_r      <= peak_index_nxt;
      trigger_count_r   <= trigger_count_nxt;
    end
  end

endmodule

>>> design/gszre_out_reg.sv
// ---------------------------------------------------------------------------
// gszre_out_reg
// Result register that holds a result until the downstream side takes it.
// ---------------------------------------------------------------------------
module gszre_out_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  gszre_pkg::result_t                  res,
  output logic                                can_load,
  output logic                                tvalid,
  input  logic                                tready,
  output logic [gszre_pkg::OutDataW-1:0]      tdata,
  output logic [1:0]                          tuser
);

  logic               valid_r, valid_nxt;
  gszre_pkg::result_t res_r;

  assign can_load  = !valid_r || tready;
  assign valid_nxt = can_load ? (fire && res.has_result) : valid_r;

  assign tvalid = valid_r;
  assign tuser  = res_r.kind;
  assign tdata  = {res_r.time_out, res_r.peak_position, res_r.peak_value,
                   res_r.intensity_sum, res_r.sample_total, res_r.scan_number,
                   res_r.value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && fire && res.has_result) begin
      res_r <= res;
    end
  end

endmodule

>>> design/gated_sample_zero_run_encoder.sv
// ---------------------------------------------------------------------------
// gated_sample_zero_run_encoder
// Encodes gate, sample and end-of-trigger requests into zero-run counts,
// shifted sample values and per-trigger summaries.
// ---------------------------------------------------------------------------
// The block takes one request per clock while the result register can load
// (it is empty or out_tready is high). An accepted request is held in the
// input register, encoded, then held in the result register; the rate is set
// by these two registers with a single encode stage between them, and
// requests that produce no result still pass through that stage.
module gated_sample_zero_run_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0: gate_start, gate_stop, raw_word, trigger_time.
  input  logic [gszre_pkg::InDataW-1:0]    in_tdata,
  // Fields from bit 0: cmd (2 bits), upper_half (1 bit).
  input  logic [2:0]                       in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: value, scan_number, sample_total, intensity_sum,
  // peak_value, peak_position, time_out.
  output logic [gszre_pkg::OutDataW-1:0]   out_tdata,
  // Field: kind.
  output logic [1:0]                       out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [gszre_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  logic [gszre_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic [gszre_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  gszre_pkg::cfg_t    cfg;
  gszre_pkg::item_t   item_r;
  gszre_pkg::result_t res;
  logic               s1_valid_r, s1_valid_nxt;
  logic               can_load;
  logic               fire;
  logic               in_acc;

  assign cfg_pready   = 1'b1;
  assign fire         = s1_valid_r && can_load;
  assign in_tready    = !s1_valid_r || can_load;
  assign in_acc       = in_tvalid && in_tready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd          <= gszre_pkg::cmd_t'(in_tuser[1:0]);
      item_r.upper_half   <= in_tuser[2];
      item_r.gate_start   <= in_tdata[31:0];
      item_r.gate_stop    <= in_tdata[63:32];
      item_r.raw_word     <= in_tdata[95:64];
      item_r.trigger_time <= in_tdata[159:96];
    end
  end

  gszre_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  gszre_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  gszre_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .can_load (can_load),
    .tvalid   (out_tvalid),
    .tready   (out_tready),
    .tdata    (out_tdata),
    .tuser    (out_tuser)
  );

endmodule

>>> design/gszre_checker.sv
// ---------------------------------------------------------------------------
// gszre_checker
// Port-level checks of the encoder's result stream, bound to the top level.
// ---------------------------------------------------------------------------
module gszre_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [gszre_pkg::OutDataW-1:0]   out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_zero_run_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gszre_pkg::KIND_ZERO_RUN
      |-> out_tdata[31] && out_tdata[271:32] == '0)
    else $error("zero-run result not negative or has stray fields");

  a_sample_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gszre_pkg::KIND_SAMPLE |-> out_tdata[271:32] == '0)
    else $error("sample result has stray fields");

  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == gszre_pkg::KIND_SUMMARY |-> out_tdata[31:0] == '0)
    else $error("summary result has nonzero value field");

endmodule

bind gated_sample_zero_run_encoder gszre_checker u_gszre_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
